// File: sv/sflx_pkg.sv
package sflx_pkg;

	// byte codes used by the lexer
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NEWLINE  = 2'd1;
	localparam logic [1:0] ERR_ESCAPE   = 2'd2;
	localparam logic [1:0] ERR_UNTERM   = 2'd3;

	// one result request
	typedef struct packed {
		logic [7:0] token_byte;
		logic       token_first;
		logic       token_last;
		logic       byte_valid;
		logic [1:0] error_code;
		logic       stream_done;
	} res_t;

	// results of one input byte: one or two
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} grp_t;

	function automatic res_t mk_byte(input logic [7:0] b, input logic first,
			input logic last);
		res_t r;
		r.token_byte  = b;
		r.token_first = first;
		r.token_last  = last;
		r.byte_valid  = 1'b1;
		r.error_code  = ERR_NONE;
		r.stream_done = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_flag(input logic [1:0] code, input logic done);
		res_t r;
		r = '0;
		r.error_code  = code;
		r.stream_done = done;
		return r;
	endfunction

	function automatic logic res_present(input res_t r);
		return r.byte_valid || (r.error_code != ERR_NONE) || r.stream_done;
	endfunction

endpackage

// File: sv/sflx_front.sv
module sflx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              end_of_input,
	output logic              push,
	output sflx_pkg::grp_t    push_grp
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_QUOTE   = 3'd2;
	localparam logic [2:0] MODE_BARE    = 3'd3;
	localparam logic [2:0] MODE_ERROR   = 3'd4;

	logic [2:0] mode_q, mode_d;
	logic       esc_q, esc_d;
	logic [7:0] hb_q, hb_d;
	logic       hv_q, hv_d;
	logic       hf_q, hf_d;

	logic           is_ws, is_delim;
	sflx_pkg::res_t st_res, res_a, res_b;
	logic [2:0]     st_mode;
	logic           st_hold;
	logic           esc_ok;
	logic [7:0]     esc_val;

	// byte classes
	always_comb begin
		is_ws    = (in_byte == sflx_pkg::CH_SPACE) || (in_byte inside {[8'h09:8'h0D]});
		is_delim = is_ws || (in_byte == sflx_pkg::CH_QUOTE) ||
			(in_byte == sflx_pkg::CH_LBRK) || (in_byte == sflx_pkg::CH_RBRK);
	end

	// decode of a byte arriving between tokens
	always_comb begin
		st_res  = '0;
		st_mode = MODE_IDLE;
		st_hold = 1'b0;
		if (is_ws) begin
			st_mode = MODE_IDLE;
		end else if (in_byte == sflx_pkg::CH_QUOTE) begin
			st_res  = sflx_pkg::mk_byte(in_byte, 1'b1, 1'b0);
			st_mode = MODE_QUOTE;
		end else if (in_byte == sflx_pkg::CH_LBRK || in_byte == sflx_pkg::CH_RBRK) begin
			st_res = sflx_pkg::mk_byte(in_byte, 1'b1, 1'b1);
		end else if (in_byte == sflx_pkg::CH_HASH) begin
			st_mode = MODE_COMMENT;
		end else begin
			st_hold = 1'b1;
			st_mode = MODE_BARE;
		end
	end

	// escape resolution
	always_comb begin
		esc_ok  = 1'b1;
		esc_val = in_byte;
		case (in_byte)
			sflx_pkg::CH_LOW_B:  esc_val = sflx_pkg::CH_BS;
			sflx_pkg::CH_LOW_F:  esc_val = sflx_pkg::CH_FF;
			sflx_pkg::CH_LOW_N:  esc_val = sflx_pkg::CH_LF;
			sflx_pkg::CH_LOW_R:  esc_val = sflx_pkg::CH_CR;
			sflx_pkg::CH_LOW_T:  esc_val = sflx_pkg::CH_TAB;
			sflx_pkg::CH_BSLASH: esc_val = sflx_pkg::CH_BSLASH;
			sflx_pkg::CH_APOS:   esc_val = sflx_pkg::CH_APOS;
			sflx_pkg::CH_QUOTE:  esc_val = sflx_pkg::CH_QUOTE;
			default:             esc_ok  = 1'b0;
		endcase
	end

	// lexer step: res_a is the held bare-word byte, res_b the rest
	always_comb begin
		res_a  = '0;
		res_b  = '0;
		mode_d = mode_q;
		esc_d  = esc_q;
		hb_d   = hb_q;
		hv_d   = hv_q;
		hf_d   = hf_q;
		if (end_of_input) begin
			if (mode_q == MODE_BARE && hv_q) begin
				res_a = sflx_pkg::mk_byte(hb_q, hf_q, 1'b1);
			end
			res_b  = sflx_pkg::mk_flag((mode_q == MODE_QUOTE) ? sflx_pkg::ERR_UNTERM :
				sflx_pkg::ERR_NONE, 1'b1);
			mode_d = MODE_IDLE;
			esc_d  = 1'b0;
			hb_d   = '0;
			hv_d   = 1'b0;
			hf_d   = 1'b0;
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					res_b  = st_res;
					mode_d = st_mode;
					if (st_hold) begin
						hb_d = in_byte;
						hv_d = 1'b1;
						hf_d = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (in_byte == sflx_pkg::CH_CR || in_byte == sflx_pkg::CH_LF) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_QUOTE: begin
					if (in_byte == sflx_pkg::CH_LF) begin
						res_b  = sflx_pkg::mk_flag(sflx_pkg::ERR_NEWLINE, 1'b0);
						mode_d = MODE_ERROR;
						esc_d  = 1'b0;
					end else if (esc_q) begin
						esc_d = 1'b0;
						if (!esc_ok) begin
							res_b  = sflx_pkg::mk_flag(sflx_pkg::ERR_ESCAPE, 1'b0);
							mode_d = MODE_ERROR;
						end else if (in_byte == sflx_pkg::CH_QUOTE) begin
							res_b  = sflx_pkg::mk_byte(esc_val, 1'b0, 1'b1);
							mode_d = MODE_IDLE;
						end else begin
							res_b = sflx_pkg::mk_byte(esc_val, 1'b0, 1'b0);
						end
					end else if (in_byte == sflx_pkg::CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (in_byte == sflx_pkg::CH_QUOTE) begin
						res_b  = sflx_pkg::mk_byte(in_byte, 1'b0, 1'b1);
						mode_d = MODE_IDLE;
					end else begin
						res_b = sflx_pkg::mk_byte(in_byte, 1'b0, 1'b0);
					end
				end
				MODE_BARE: begin
					if (is_delim) begin
						if (hv_q) begin
							res_a = sflx_pkg::mk_byte(hb_q, hf_q, 1'b1);
						end
						hb_d   = '0;
						hv_d   = 1'b0;
						hf_d   = 1'b0;
						res_b  = st_res;
						mode_d = st_mode;
					end else begin
						if (hv_q) begin
							res_a = sflx_pkg::mk_byte(hb_q, hf_q, 1'b0);
						end
						hb_d = in_byte;
						hv_d = 1'b1;
						hf_d = 1'b0;
					end
				end
				default: begin
					mode_d = MODE_ERROR;
				end
			endcase
		end
	end

	// pack the results of this byte into one queue entry
	always_comb begin
		push_grp = '0;
		if (res_a.byte_valid) begin
			push_grp.r0  = res_a;
			push_grp.r1  = res_b;
			push_grp.two = sflx_pkg::res_present(res_b);
		end else begin
			push_grp.r0 = res_b;
		end
		push = accept && (res_a.byte_valid || sflx_pkg::res_present(res_b));
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= 1'b0;
			hb_q   <= '0;
			hv_q   <= 1'b0;
			hf_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			hb_q   <= hb_d;
			hv_q   <= hv_d;
			hf_q   <= hf_d;
		end
	end

	// error mode swallows every byte but end of input
	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !end_of_input && mode_q == MODE_ERROR) |-> !push)
		else $error("request produced in error mode");

	// a held byte exists only inside a bare word
	a_held_in_bare: assert property (@(posedge clk) disable iff (!arst_n)
		hv_q |-> (mode_q == MODE_BARE))
		else $error("held byte outside bare word");

endmodule

// File: sv/sflx_fifo.sv
module sflx_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sflx_pkg::grp_t    push_grp,
	output logic              full,
	input  logic              pop,
	output sflx_pkg::grp_t    head_grp,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sflx_pkg::grp_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_grp = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/sflx_back.sv
module sflx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sflx_pkg::grp_t    head_grp,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sflx_pkg::res_t    out_res
);

	sflx_pkg::grp_t grp_q;
	logic           sel_q;
	logic           valid_q;
	logic           last;

	assign last      = sel_q || !grp_q.two;
	assign pop       = !empty && (!valid_q || (out_ready && last));
	assign out_valid = valid_q;
	assign out_res   = sel_q ? grp_q.r1 : grp_q.r0;

	// entry payload
	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head_grp;
		end
	end

	// output sequencing: first result, then the second if there is one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
				sel_q   <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	// second result only shown when the entry holds one
	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && sel_q) |-> grp_q.two)
		else $error("second result shown from single entry");

endmodule

// File: sv/scene_file_lexer_unit.sv
// Scene-file lexer. Takes one byte of scene text per cycle and returns the bytes of
// its tokens, marked first and last, with escapes resolved and quotes kept; errors
// and end of stream come back as requests without a token byte. A byte is accepted
// every cycle while the result queue has room; each byte gives zero, one or two
// results, and the output side drains one result per cycle while out_ready is high,
// so a byte that gives two results holds the output for both in turn. The front end
// classifies each byte combinationally in the cycle it is accepted and writes the
// result queue; the back end pops the entry from there into the output register.
// The queue holds FIFO_DEPTH entries, one per input byte that produced results.
module scene_file_lexer_unit #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] token_byte,
	output logic       token_first,
	output logic       token_last,
	output logic       byte_valid,
	output logic [1:0] error_code,
	output logic       stream_done
);

	logic           accept, push, full, pop, empty;
	sflx_pkg::grp_t push_grp, head_grp;
	sflx_pkg::res_t out_res;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// front end: classify bytes and run the token state
	sflx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.push_grp     (push_grp)
	);

	// result queue
	sflx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.full     (full),
		.pop      (pop),
		.head_grp (head_grp),
		.empty    (empty)
	);

	// back end: output register
	sflx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_grp  (head_grp),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign token_byte  = out_res.token_byte;
	assign token_first = out_res.token_first;
	assign token_last  = out_res.token_last;
	assign byte_valid  = out_res.byte_valid;
	assign error_code  = out_res.error_code;
	assign stream_done = out_res.stream_done;

	// a token byte never carries an error or the end mark
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid) |-> (error_code == sflx_pkg::ERR_NONE && !stream_done))
		else $error("token byte with error or end mark");

	// a request without a byte is an error or the end of stream
	a_flag_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (error_code != sflx_pkg::ERR_NONE || stream_done))
		else $error("empty request");

	// unterminated quote is reported only with the end mark
	a_unterm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == sflx_pkg::ERR_UNTERM) |-> stream_done)
		else $error("unterminated quote without end mark");

endmodule

// File: verif/scene_file_lexer_unit_test.sv
`timescale 1ns / 1ps

module scene_file_lexer_unit_test;

	localparam int   RANDOM_ITEMS = 1400;
	localparam int   HOLD_CYCLES  = 80;
	localparam int   IDLE_LIMIT   = 2000;
	localparam int   DRAIN_CYCLES = 16;
	localparam int   PREDICT      = -1;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam sflx_pkg::res_t NO_RES = '0;

	typedef enum logic [2:0] {
		LX_IDLE,
		LX_COMMENT,
		LX_QUOTED,
		LX_WORD,
		LX_FAULT
	} lex_state_t;

	// one row of the directed table; n_typed < 0 means use the lexer model
	typedef struct {
		logic [7:0]     text;
		logic           eos;
		int             n_typed;
		sflx_pkg::res_t r0;
		sflx_pkg::res_t r1;
	} step_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] token_byte;
	logic       token_first;
	logic       token_last;
	logic       byte_valid;
	logic [1:0] error_code;
	logic       stream_done;

	// lexer model state
	lex_state_t     lx_state;
	logic           lx_escape;
	logic [7:0]     lx_held;
	logic           lx_held_ok;
	logic           lx_held_first;
	sflx_pkg::res_t step_res [2];
	int             step_n;

	sflx_pkg::res_t token_q [$];
	logic [8:0]     text_q [$];
	step_row_t      rows [$];
	int             items_sent;
	int             burst_left;
	int             mismatches;
	int             idle_cycles;
	logic           hold_req;

	scene_file_lexer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_byte   (token_byte),
		.token_first  (token_first),
		.token_last   (token_last),
		.byte_valid   (byte_valid),
		.error_code   (error_code),
		.stream_done  (stream_done)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic sflx_pkg::res_t token_res(input logic [7:0] c, input logic first,
			input logic last);
		sflx_pkg::res_t r;
		r = '0;
		r.token_byte  = c;
		r.token_first = first;
		r.token_last  = last;
		r.byte_valid  = 1'b1;
		return r;
	endfunction

	function automatic sflx_pkg::res_t status_res(input logic [1:0] code, input logic done);
		sflx_pkg::res_t r;
		r = '0;
		r.error_code  = code;
		r.stream_done = done;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == sflx_pkg::CH_SPACE || (c >= sflx_pkg::CH_TAB && c <= sflx_pkg::CH_CR);
	endfunction

	function automatic logic breaks_word(input logic [7:0] c);
		return is_space(c) || c == sflx_pkg::CH_QUOTE || c == sflx_pkg::CH_LBRK ||
			c == sflx_pkg::CH_RBRK;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c, output logic ok);
		ok = 1'b1;
		case (c)
			sflx_pkg::CH_LOW_B: return sflx_pkg::CH_BS;
			sflx_pkg::CH_LOW_F: return sflx_pkg::CH_FF;
			sflx_pkg::CH_LOW_N: return sflx_pkg::CH_LF;
			sflx_pkg::CH_LOW_R: return sflx_pkg::CH_CR;
			sflx_pkg::CH_LOW_T: return sflx_pkg::CH_TAB;
			sflx_pkg::CH_BSLASH, sflx_pkg::CH_APOS, sflx_pkg::CH_QUOTE: return c;
			default: begin
				ok = 1'b0;
				return 8'h00;
			end
		endcase
	endfunction

	function automatic void emit(input sflx_pkg::res_t r);
		step_res[step_n] = r;
		step_n++;
	endfunction

	function automatic void clear_lexer();
		lx_state      = LX_IDLE;
		lx_escape     = 1'b0;
		lx_held       = 8'h00;
		lx_held_ok    = 1'b0;
		lx_held_first = 1'b0;
	endfunction

	function automatic void fault(input logic [1:0] code);
		emit(status_res(code, 1'b0));
		lx_state  = LX_FAULT;
		lx_escape = 1'b0;
	endfunction

	// byte arriving between tokens
	function automatic void open_token(input logic [7:0] c);
		if (is_space(c))
			return;
		if (c == sflx_pkg::CH_QUOTE) begin
			emit(token_res(c, 1'b1, 1'b0));
			lx_state  = LX_QUOTED;
			lx_escape = 1'b0;
		end else if (c == sflx_pkg::CH_LBRK || c == sflx_pkg::CH_RBRK) begin
			emit(token_res(c, 1'b1, 1'b1));
		end else if (c == sflx_pkg::CH_HASH) begin
			lx_state = LX_COMMENT;
		end else begin
			lx_held       = c;
			lx_held_ok    = 1'b1;
			lx_held_first = 1'b1;
			lx_state      = LX_WORD;
		end
	endfunction

	// results of one accepted byte, left in step_res / step_n
	function automatic void lex_byte(input logic [7:0] c, input logic eos);
		logic [7:0] r;
		logic       ok;
		step_n = 0;
		if (eos) begin
			if (lx_state == LX_WORD && lx_held_ok)
				emit(token_res(lx_held, lx_held_first, 1'b1));
			emit(status_res(lx_state == LX_QUOTED ? sflx_pkg::ERR_UNTERM :
				sflx_pkg::ERR_NONE, 1'b1));
			clear_lexer();
			return;
		end
		case (lx_state)
			LX_IDLE: open_token(c);
			LX_COMMENT: begin
				if (c == sflx_pkg::CH_CR || c == sflx_pkg::CH_LF)
					lx_state = LX_IDLE;
			end
			LX_QUOTED: begin
				if (c == sflx_pkg::CH_LF) begin
					fault(sflx_pkg::ERR_NEWLINE);
				end else if (lx_escape) begin
					lx_escape = 1'b0;
					r = unescape(c, ok);
					if (!ok) begin
						fault(sflx_pkg::ERR_ESCAPE);
					end else if (c == sflx_pkg::CH_QUOTE) begin
						// an escaped quote still closes the token
						emit(token_res(r, 1'b0, 1'b1));
						lx_state = LX_IDLE;
					end else begin
						emit(token_res(r, 1'b0, 1'b0));
					end
				end else if (c == sflx_pkg::CH_BSLASH) begin
					lx_escape = 1'b1;
				end else if (c == sflx_pkg::CH_QUOTE) begin
					emit(token_res(c, 1'b0, 1'b1));
					lx_state = LX_IDLE;
				end else begin
					emit(token_res(c, 1'b0, 1'b0));
				end
			end
			LX_WORD: begin
				if (breaks_word(c)) begin
					if (lx_held_ok)
						emit(token_res(lx_held, lx_held_first, 1'b1));
					lx_held       = 8'h00;
					lx_held_ok    = 1'b0;
					lx_held_first = 1'b0;
					lx_state      = LX_IDLE;
					open_token(c);
				end else begin
					if (lx_held_ok)
						emit(token_res(lx_held, lx_held_first, 1'b0));
					lx_held       = c;
					lx_held_ok    = 1'b1;
					lx_held_first = 1'b0;
				end
			end
			default: lx_state = LX_FAULT;
		endcase
	endfunction

	function automatic void add_row(input logic [7:0] c, input logic eos,
			input int n_typed, input sflx_pkg::res_t r0, input sflx_pkg::res_t r1);
		step_row_t s;
		s.text    = c;
		s.eos     = eos;
		s.n_typed = n_typed;
		s.r0      = r0;
		s.r1      = r1;
		rows.insert(rows.size(), s);
	endfunction

	function automatic void add_text(input logic [7:0] c);
		text_q.insert(text_q.size(), {1'b0, c});
	endfunction

	// end of stream, with a random byte that the lexer ignores
	function automatic void add_end();
		text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
	endfunction

	function automatic logic [7:0] space_char();
		case ($urandom_range(0, 5))
			0: return sflx_pkg::CH_SPACE;
			1: return sflx_pkg::CH_TAB;
			2: return sflx_pkg::CH_LF;
			3: return CH_VT;
			4: return sflx_pkg::CH_FF;
			default: return sflx_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(0, 6))
			0: return sflx_pkg::CH_LOW_B;
			1: return sflx_pkg::CH_LOW_F;
			2: return sflx_pkg::CH_LOW_N;
			3: return sflx_pkg::CH_LOW_R;
			4: return sflx_pkg::CH_LOW_T;
			5: return sflx_pkg::CH_BSLASH;
			default: return sflx_pkg::CH_APOS;
		endcase
	endfunction

	function automatic logic [7:0] quoted_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == sflx_pkg::CH_QUOTE || c == sflx_pkg::CH_BSLASH || c == sflx_pkg::CH_LF);
		return c;
	endfunction

	// one piece of scene text: mostly well formed, some broken, some noise
	function automatic void compose_fragment();
		int         kind;
		int         len;
		logic [7:0] c;
		logic [7:0] r;
		logic       ok;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			// bare word
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				do
					c = 8'($urandom_range(0, 255));
				while (breaks_word(c) || (i == 0 && c == sflx_pkg::CH_HASH));
				add_text(c);
			end
		end else if (kind < 50) begin
			// separators
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				add_text(space_char());
		end else if (kind < 72) begin
			// quoted token with legal escapes
			add_text(sflx_pkg::CH_QUOTE);
			len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					add_text(sflx_pkg::CH_BSLASH);
					add_text(escape_letter());
				end else begin
					add_text(quoted_char());
				end
			end
			if ($urandom_range(0, 5) == 0)
				add_text(sflx_pkg::CH_BSLASH);
			add_text(sflx_pkg::CH_QUOTE);
		end else if (kind < 80) begin
			add_text($urandom_range(0, 1) ? sflx_pkg::CH_LBRK : sflx_pkg::CH_RBRK);
		end else if (kind < 87) begin
			// comment up to a line end
			add_text(sflx_pkg::CH_HASH);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == sflx_pkg::CH_CR || c == sflx_pkg::CH_LF);
				add_text(c);
			end
			add_text($urandom_range(0, 1) ? sflx_pkg::CH_CR : sflx_pkg::CH_LF);
		end else if (kind < 92) begin
			add_end();
		end else if (kind < 97) begin
			// quoted token, usually broken, then junk bytes and end of stream
			add_text(sflx_pkg::CH_QUOTE);
			len = $urandom_range(0, 3);
			for (int i = 0; i < len; i++)
				add_text(quoted_char());
			case ($urandom_range(0, 3))
				0: begin
					add_text(sflx_pkg::CH_BSLASH);
					do begin
						c = 8'($urandom_range(0, 255));
						r = unescape(c, ok);
					end while (ok || c == sflx_pkg::CH_LF);
					add_text(c);
				end
				1: add_text(sflx_pkg::CH_LF);
				2: begin
					add_text(sflx_pkg::CH_BSLASH);
					add_text(sflx_pkg::CH_LF);
				end
				default: ;
			endcase
			len = $urandom_range(0, 4);
			for (int i = 0; i < len; i++)
				add_text(8'($urandom_range(0, 255)));
			add_end();
		end else begin
			// raw noise
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++)
				add_text(8'($urandom_range(0, 255)));
		end
	endfunction

	// offer one byte, wait for the request to go through, record what it gives
	task automatic send_byte(input logic [7:0] c, input logic eos, input int n_typed,
			input sflx_pkg::res_t t0, input sflx_pkg::res_t t1);
		in_valid     <= 1'b1;
		in_byte      <= c;
		end_of_input <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		lex_byte(c, eos);
		if (n_typed < 0) begin
			for (int i = 0; i < step_n; i++)
				token_q.insert(token_q.size(), step_res[i]);
		end else begin
			if (n_typed > 0)
				token_q.insert(token_q.size(), t0);
			if (n_typed > 1)
				token_q.insert(token_q.size(), t1);
		end
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
	endtask

	function automatic string res_text(input sflx_pkg::res_t r);
		return $sformatf("byte %02h first %b last %b valid %b err %0d done %b",
			r.token_byte, r.token_first, r.token_last, r.byte_valid,
			r.error_code, r.stream_done);
	endfunction

	task automatic report(input string what, input sflx_pkg::res_t want,
			input sflx_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %s, got %s", what, res_text(want), res_text(got));
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		sflx_pkg::res_t got;
		sflx_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			got.token_byte  = token_byte;
			got.token_first = token_first;
			got.token_last  = token_last;
			got.byte_valid  = byte_valid;
			got.error_code  = error_code;
			got.stream_done = stream_done;
			if (token_q.size() == 0) begin
				report("unexpected result", NO_RES, got);
			end else begin
				want = token_q.pop_front();
				if (got.token_byte !== want.token_byte || got.token_first !== want.token_first
						|| got.token_last !== want.token_last
						|| got.byte_valid !== want.byte_valid
						|| got.error_code !== want.error_code
						|| got.stream_done !== want.stream_done)
					report("result mismatch", want, got);
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("scene_file_lexer_unit test failed");
			$finish;
		end
	end

	// receiver: stall pattern picked at random from four styles, long hold-off on demand
	initial begin : receiver
		int rx_cnt;
		int rx_style;
		out_ready = 1'b0;
		rx_cnt    = 0;
		rx_style  = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (rx_cnt % 50 == 0)
					rx_style = $urandom_range(0, 3);
				case (rx_style)
					0: out_ready <= 1'b1;
					1: out_ready <= rx_cnt[0];
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
				rx_cnt++;
				@(posedge clk);
			end
		end
	end

	// sender and run control
	initial begin : stimulus
		logic [8:0] t;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_byte      = 8'h00;
		end_of_input = 1'b0;
		hold_req     = 1'b0;
		items_sent   = 0;
		mismatches   = 0;
		idle_cycles  = 0;
		burst_left   = $urandom_range(1, 48);
		clear_lexer();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: extremes, every token kind, every error
		add_row(8'hA5, 1'b1, 1, status_res(sflx_pkg::ERR_NONE, 1'b1), NO_RES);
		add_row(sflx_pkg::CH_LBRK, 1'b0, 1,
			token_res(sflx_pkg::CH_LBRK, 1'b1, 1'b1), NO_RES);
		add_row(sflx_pkg::CH_RBRK, 1'b0, 1,
			token_res(sflx_pkg::CH_RBRK, 1'b1, 1'b1), NO_RES);
		add_row(8'h61,               1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'hFF,               1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_SPACE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_QUOTE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_BSLASH, 1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_LOW_N,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_BSLASH, 1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_QUOTE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_HASH,   1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'h78,               1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_CR,     1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'h00,               1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_QUOTE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_BSLASH, 1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'h71, 1'b0, 1, status_res(sflx_pkg::ERR_ESCAPE, 1'b0), NO_RES);
		add_row(8'h7A, 1'b0, 0, NO_RES, NO_RES);
		add_row(8'h00, 1'b1, 1, status_res(sflx_pkg::ERR_NONE, 1'b1), NO_RES);
		add_row(sflx_pkg::CH_QUOTE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(sflx_pkg::CH_LF, 1'b0, 1, status_res(sflx_pkg::ERR_NEWLINE, 1'b0), NO_RES);
		add_row(8'hFF, 1'b1, 1, status_res(sflx_pkg::ERR_NONE, 1'b1), NO_RES);
		add_row(sflx_pkg::CH_QUOTE,  1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'h5A, 1'b1, 1, status_res(sflx_pkg::ERR_UNTERM, 1'b1), NO_RES);
		add_row(8'h77,               1'b0, PREDICT, NO_RES, NO_RES);
		add_row(8'h00,               1'b1, PREDICT, NO_RES, NO_RES);
		foreach (rows[i])
			send_byte(rows[i].text, rows[i].eos, rows[i].n_typed, rows[i].r0, rows[i].r1);

		// random scene text, with the output held off twice to fill the block
		hold_req   = 1'b1;
		burst_left = 200;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS || text_q.size() != 0) begin
			if (text_q.size() == 0)
				compose_fragment();
			if (items_sent == RANDOM_ITEMS / 2) begin
				hold_req   = 1'b1;
				burst_left = 200;
			end
			t = text_q.pop_front();
			send_byte(t[7:0], t[8], PREDICT, NO_RES, NO_RES);
		end
		send_byte(8'h00, 1'b1, PREDICT, NO_RES, NO_RES);
		in_valid <= 1'b0;

		// drain, then allow for anything still in flight
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && token_q.size() == 0)
			$display("scene_file_lexer_unit test passed");
		else
			$display("scene_file_lexer_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/sflx_pkg.sv
sv/sflx_front.sv
sv/sflx_fifo.sv
sv/sflx_back.sv
sv/scene_file_lexer_unit.sv
verif/scene_file_lexer_unit_test.sv
